FILE: sv/nfps_pkg.sv
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared codes, fixed result widths and the cell control type of the
// nearest-four priority selector.
// ----------------------------------------------------------------------------
package nfps_pkg;

  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_BEGIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFFER  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  localparam int OUT_ID_BITS   = 16;
  localparam int OUT_DIST_BITS = 34;
  localparam int OUT_DATA_W    = ((OUT_ID_BITS + OUT_DIST_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic ins;
    logic clr;
  } cell_ctl_t;

endpackage

FILE: sv/nfps_dist.sv
// ----------------------------------------------------------------------------
// nfps_dist
// Holds the query position and turns each input beat into a ranking key in a
// three-stage pipeline: coordinate differences, squares, sum.
// ----------------------------------------------------------------------------
module nfps_dist #(
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              beat,
  input  logic [nfps_pkg::MODE_W-1:0]       mode,
  input  logic [COORD_BITS-1:0]             pos_x,
  input  logic [COORD_BITS-1:0]             pos_y,
  input  logic [COORD_BITS-1:0]             pos_z,
  input  logic                              is_important,
  input  logic [ID_BITS-1:0]                light_id,
  output logic                              k_vld,
  output logic [nfps_pkg::MODE_W-1:0]       k_mode,
  output logic [2*COORD_BITS+2:0]           k_key,
  output logic [ID_BITS-1:0]                k_id
);
  import nfps_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int DIST_W = 2 * COORD_BITS + 2;

  logic [COORD_BITS-1:0] qx_r, qy_r, qz_r;

  logic                     a_vld_r;
  logic [MODE_W-1:0]        a_mode_r;
  logic                     a_imp_r;
  logic [ID_BITS-1:0]       a_id_r;
  logic signed [DW-1:0]     dx_r, dy_r, dz_r;
  logic signed [DW-1:0]     dx_nxt, dy_nxt, dz_nxt;

  logic                     b_vld_r;
  logic [MODE_W-1:0]        b_mode_r;
  logic                     b_imp_r;
  logic [ID_BITS-1:0]       b_id_r;
  logic [SQ_W-1:0]          sx_r, sy_r, sz_r;
  logic signed [2*DW-1:0]   px, py, pz;

  logic                     c_vld_r;
  logic [MODE_W-1:0]        c_mode_r;
  logic [DIST_W:0]          c_key_r;
  logic [ID_BITS-1:0]       c_id_r;
  logic [DIST_W-1:0]        dist_sum;

  assign dx_nxt = $signed({pos_x[COORD_BITS-1], pos_x}) - $signed({qx_r[COORD_BITS-1], qx_r});
  assign dy_nxt = $signed({pos_y[COORD_BITS-1], pos_y}) - $signed({qy_r[COORD_BITS-1], qy_r});
  assign dz_nxt = $signed({pos_z[COORD_BITS-1], pos_z}) - $signed({qz_r[COORD_BITS-1], qz_r});

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  assign dist_sum = DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r    <= '0;
      qy_r    <= '0;
      qz_r    <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (beat && mode == MODE_BEGIN) begin
        qx_r <= pos_x;
        qy_r <= pos_y;
        qz_r <= pos_z;
      end
      a_vld_r <= beat;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mode_r <= mode;
    a_imp_r  <= is_important;
    a_id_r   <= light_id;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    dz_r     <= dz_nxt;
    b_mode_r <= a_mode_r;
    b_imp_r  <= a_imp_r;
    b_id_r   <= a_id_r;
    sx_r     <= px[SQ_W-1:0];
    sy_r     <= py[SQ_W-1:0];
    sz_r     <= pz[SQ_W-1:0];
    c_mode_r <= b_mode_r;
    c_id_r   <= b_id_r;
    c_key_r  <= {~b_imp_r, dist_sum};
  end

  assign k_vld  = c_vld_r;
  assign k_mode = c_mode_r;
  assign k_key  = c_key_r;
  assign k_id   = c_id_r;

endmodule

FILE: sv/nfps_cell.sv
// ----------------------------------------------------------------------------
// nfps_cell
// One slot of the sorted keep list. On an insert it either keeps its entry,
// takes the candidate, or takes its upstream neighbor's entry.
// ----------------------------------------------------------------------------
module nfps_cell #(
  parameter int KEY_W = 35,
  parameter int ID_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nfps_pkg::cell_ctl_t   ctl,
  input  logic [KEY_W-1:0]      cand_key,
  input  logic [ID_W-1:0]       cand_id,
  input  logic                  prev_win,
  input  logic                  prev_valid,
  input  logic [KEY_W-1:0]      prev_key,
  input  logic [ID_W-1:0]       prev_id,
  output logic                  win,
  output logic                  valid,
  output logic [KEY_W-1:0]      key,
  output logic [ID_W-1:0]       id
);
  import nfps_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [ID_W-1:0]  id_r;

  assign win = !valid_r || (cand_key < key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.ins && prev_win) begin
      valid_r <= prev_valid;
    end else if (ctl.ins && win) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && prev_win) begin
      key_r <= prev_key;
      id_r  <= prev_id;
    end else if (ctl.ins && win) begin
      key_r <= cand_key;
      id_r  <= cand_id;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign id    = id_r;

endmodule

FILE: sv/nearest_four_priority_select.sv
// ----------------------------------------------------------------------------
// nearest_four_priority_select
// Keeps the best KEEP_COUNT candidates, important ones first and nearest
// first within a class, in a chain of slot cells, and emits them on finish.
// ----------------------------------------------------------------------------
// Begin and offer beats are taken one per cycle while no finish holds input;
// each updates the slot chain after passing the three distance stages.
// A finish beat stops input until its last result sits in the output
// register: the finish passes the same distance stages and starts emission,
// and results follow one per cycle while out_tready does not stall them.
// Synchronous active-low reset clears the query to zero and empties the slots.
// ----------------------------------------------------------------------------
module nearest_four_priority_select #(
  parameter int KEEP_COUNT = 4,
  parameter int COORD_BITS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_tvalid,
  output logic                                             in_tready,
  // pos_x, pos_y, pos_z, light_id, zero pad
  input  logic [((3*COORD_BITS+ID_BITS+7)/8)*8-1:0]        in_tdata,
  // mode, is_important
  input  logic [2:0]                                       in_tuser,
  output logic                                             out_tvalid,
  input  logic                                             out_tready,
  // sel_id, distance_sq, zero pad
  output logic [nfps_pkg::OUT_DATA_W-1:0]                  out_tdata,
  // valid_res, sel_important
  output logic [1:0]                                       out_tuser,
  output logic                                             out_tlast
);
  import nfps_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 2;
  localparam int KEY_W  = DIST_W + 1;
  localparam int IDX_W  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int DWIDE  = (DIST_W > OUT_DIST_BITS) ? DIST_W : OUT_DIST_BITS;
  localparam int IWIDE  = (ID_BITS > OUT_ID_BITS) ? ID_BITS : OUT_ID_BITS;
  localparam int PAD_W  = OUT_DATA_W - OUT_ID_BITS - OUT_DIST_BITS;

  logic                 in_beat;
  logic                 k_vld;
  logic [MODE_W-1:0]    k_mode;
  logic [KEY_W-1:0]     k_key;
  logic [ID_BITS-1:0]   k_id;
  cell_ctl_t            ctl;

  logic [KEEP_COUNT-1:0] win;
  logic [KEEP_COUNT-1:0] slot_valid;
  logic [KEEP_COUNT-1:0] valid_after;
  logic [KEY_W-1:0]      slot_key [KEEP_COUNT];
  logic [ID_BITS-1:0]    slot_id  [KEEP_COUNT];

  logic                  hold_r, hold_nxt;
  logic                  emit_r, emit_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic                  load;
  logic                  empty;
  logic                  last_sel;
  logic [KEY_W-1:0]      sel_key;
  logic [DWIDE-1:0]      sel_dist;
  logic [IWIDE-1:0]      sel_idw;

  logic [OUT_ID_BITS-1:0]   o_id_r;
  logic [OUT_DIST_BITS-1:0] o_dist_r;
  logic                     o_res_r, o_imp_r, o_last_r;

  assign in_tready = rst_n && !hold_r;
  assign in_beat   = in_tvalid && in_tready;

  nfps_dist #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (in_beat),
    .mode         (in_tuser[1:0]),
    .pos_x        (in_tdata[COORD_BITS-1:0]),
    .pos_y        (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pos_z        (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .is_important (in_tuser[2]),
    .light_id     (in_tdata[3*COORD_BITS+ID_BITS-1:3*COORD_BITS]),
    .k_vld        (k_vld),
    .k_mode       (k_mode),
    .k_key        (k_key),
    .k_id         (k_id)
  );

  assign ctl.ins = k_vld && (k_mode == MODE_OFFER);
  assign ctl.clr = k_vld && (k_mode == MODE_BEGIN);

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    logic               p_win, p_valid;
    logic [KEY_W-1:0]   p_key;
    logic [ID_BITS-1:0] p_id;

    if (i == 0) begin : g_head
      assign p_win   = 1'b0;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_id    = '0;
    end else begin : g_link
      assign p_win   = win[i-1];
      assign p_valid = slot_valid[i-1];
      assign p_key   = slot_key[i-1];
      assign p_id    = slot_id[i-1];
    end

    nfps_cell #(
      .KEY_W (KEY_W),
      .ID_W  (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cand_key   (k_key),
      .cand_id    (k_id),
      .prev_win   (p_win),
      .prev_valid (p_valid),
      .prev_key   (p_key),
      .prev_id    (p_id),
      .win        (win[i]),
      .valid      (slot_valid[i]),
      .key        (slot_key[i]),
      .id         (slot_id[i])
    );

    if (i == KEEP_COUNT - 1) begin : g_tail
      assign valid_after[i] = 1'b0;
    end else begin : g_next
      assign valid_after[i] = slot_valid[i+1];
    end
  end

  assign load     = emit_r && (!out_vld_r || out_tready);
  assign empty    = !slot_valid[0];
  assign last_sel = empty || !valid_after[idx_r];
  assign sel_key  = slot_key[idx_r];
  assign sel_dist = DWIDE'(sel_key[DIST_W-1:0]);
  assign sel_idw  = IWIDE'(slot_id[idx_r]);

  always_comb begin
    hold_nxt    = hold_r;
    emit_nxt    = emit_r;
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (in_beat && in_tuser[1:0] == MODE_FINISH) begin
      hold_nxt = 1'b1;
    end
    if (k_vld && k_mode == MODE_FINISH) begin
      emit_nxt = 1'b1;
      idx_nxt  = '0;
    end
    if (load) begin
      out_vld_nxt = 1'b1;
      idx_nxt     = idx_r + 1'b1;
      if (last_sel) begin
        emit_nxt = 1'b0;
        hold_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r    <= 1'b0;
      emit_r    <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      hold_r    <= hold_nxt;
      emit_r    <= emit_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_last_r <= last_sel;
      if (empty) begin
        o_res_r  <= 1'b0;
        o_imp_r  <= 1'b0;
        o_id_r   <= '0;
        o_dist_r <= '0;
      end else begin
        o_res_r  <= 1'b1;
        o_imp_r  <= ~sel_key[DIST_W];
        o_id_r   <= sel_idw[OUT_ID_BITS-1:0];
        o_dist_r <= sel_dist[OUT_DIST_BITS-1:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, o_dist_r, o_id_r};
  assign out_tuser  = {o_imp_r, o_res_r};
  assign out_tlast  = o_last_r;

endmodule
